@@ rtl/vnf_pkg.sv @@
// Shared types and constants for the fractal value noise pipeline.
`timescale 1ns / 1ps
`default_nettype none
package vnf_pkg;

   typedef logic signed [31:0] coord_type;
   typedef logic        [31:0] lattice_type;
   typedef logic        [15:0] frac_type;
   typedef logic        [16:0] weight_type;
   typedef logic signed [17:0] corner_type;
   typedef logic signed [17:0] noise_type;
   typedef logic signed [33:0] row_type;
   typedef logic signed [49:0] oct_type;

   localparam int OCT_W       = 50;
   localparam int HASH_STAGES = 5;
   localparam int OCT_STAGES  = 10;
   localparam int HASH_SHIFT  = 13;

   localparam lattice_type HASH_MUL_X = 32'd73856093;
   localparam lattice_type HASH_MUL_Z = 32'd19349663;
   localparam lattice_type HASH_MUL_Q = 32'd15731;
   localparam lattice_type HASH_ADD_L = 32'd789221;
   localparam lattice_type HASH_ADD_C = 32'd1376312589;

   localparam corner_type  ONE_Q16    = 18'sd65536;
   localparam logic [17:0] EASE_THREE = 18'd196608;

endpackage
`default_nettype wire

@@ rtl/vnf_channels.sv @@
// Valid/ready channel interfaces for coordinate requests and noise responses.
`timescale 1ns / 1ps
`default_nettype none
interface vnf_req_if import vnf_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type coord_x;
   coord_type coord_z;

   modport source (output valid, output coord_x, output coord_z, input ready);
   modport sink   (input valid, input coord_x, input coord_z, output ready);
endinterface

interface vnf_rsp_if import vnf_pkg::*; ();
   logic      valid;
   logic      ready;
   noise_type noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

@@ rtl/vnf_hash.sv @@
// Pipelined 32-bit lattice corner hash, five register stages.
`timescale 1ns / 1ps
`default_nettype none
module vnf_hash import vnf_pkg::*; (
   input  wire logic                   clock,
   input  wire logic [HASH_STAGES-1:0] stage_en,
   input  wire lattice_type            cx,
   input  wire lattice_type            cz,
   output corner_type                  value
);

   lattice_type px_in, pz_in, px_ff, pz_ff;
   lattice_type n_mix, n_in, nn_in, n_ff, nn_ff;
   lattice_type t_in, t_ff, nd_ff;
   lattice_type m_in, m_ff, mm;
   corner_type  value_in, value_ff;

   always_comb begin
      px_in    = 32'(cx * HASH_MUL_X);
      pz_in    = 32'(cz * HASH_MUL_Z);
      n_mix    = px_ff ^ pz_ff;
      n_in     = n_mix ^ (n_mix << HASH_SHIFT);
      nn_in    = 32'(n_in * n_in);
      t_in     = 32'(nn_ff * HASH_MUL_Q + HASH_ADD_L);
      m_in     = 32'(nd_ff * t_ff);
      mm       = m_ff + HASH_ADD_C;
      // bit 31 is masked off; keep the top 17 of the remaining 31
      value_in = ONE_Q16 - $signed({1'b0, mm[30:14]});
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         px_ff <= px_in;
         pz_ff <= pz_in;
      end
      if (stage_en[1]) begin
         n_ff  <= n_in;
         nn_ff <= nn_in;
      end
      if (stage_en[2]) begin
         t_ff  <= t_in;
         nd_ff <= n_ff;
      end
      if (stage_en[3]) begin
         m_ff <= m_in;
      end
      if (stage_en[4]) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule
`default_nettype wire

@@ rtl/vnf_octave.sv @@
// One noise octave: lattice split, four corner hashes, smoothstep, bilinear blend.
`timescale 1ns / 1ps
`default_nettype none
module vnf_octave import vnf_pkg::*; #(
   parameter int OCTAVE        = 0,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic [OCT_STAGES-1:0] stage_en,
   input  wire coord_type             coord_x,
   input  wire coord_type             coord_z,
   output oct_type                    oct
);

   typedef logic signed [18:0] diff_type;
   typedef logic signed [34:0] rdiff_type;

   // stage 0: scale by 2^OCTAVE, split into lattice index and fraction
   logic [63:0] x_sh, z_sh;
   frac_type    fx_q, fz_q;
   lattice_type lx_ff, lz_ff, lx1_ff, lz1_ff;
   frac_type    fx_ff, fz_ff;

   assign x_sh = {{32{coord_x[31]}}, coord_x} << OCTAVE;
   assign z_sh = {{32{coord_z[31]}}, coord_z} << OCTAVE;

   if (FRACTION_BITS >= 16) begin : g_frac_trunc
      assign fx_q = x_sh[FRACTION_BITS-1 -: 16];
      assign fz_q = z_sh[FRACTION_BITS-1 -: 16];
   end else begin : g_frac_pad
      assign fx_q = {x_sh[FRACTION_BITS-1:0], {(16-FRACTION_BITS){1'b0}}};
      assign fz_q = {z_sh[FRACTION_BITS-1:0], {(16-FRACTION_BITS){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         lx_ff  <= x_sh[FRACTION_BITS +: 32];
         lz_ff  <= z_sh[FRACTION_BITS +: 32];
         lx1_ff <= x_sh[FRACTION_BITS +: 32] + 32'd1;
         lz1_ff <= z_sh[FRACTION_BITS +: 32] + 32'd1;
         fx_ff  <= fx_q;
         fz_ff  <= fz_q;
      end
   end

   // stages 1..5: corner hashes
   corner_type c00, c10, c01, c11;

   vnf_hash u_h00 (.clock, .stage_en(stage_en[HASH_STAGES:1]),
                   .cx(lx_ff),  .cz(lz_ff),  .value(c00));
   vnf_hash u_h10 (.clock, .stage_en(stage_en[HASH_STAGES:1]),
                   .cx(lx1_ff), .cz(lz_ff),  .value(c10));
   vnf_hash u_h01 (.clock, .stage_en(stage_en[HASH_STAGES:1]),
                   .cx(lx_ff),  .cz(lz1_ff), .value(c01));
   vnf_hash u_h11 (.clock, .stage_en(stage_en[HASH_STAGES:1]),
                   .cx(lx1_ff), .cz(lz1_ff), .value(c11));

   // stages 1..2: smoothstep, in parallel with the hash
   logic [31:0] sqx, sqz;
   logic [17:0] kx, kz;
   logic [33:0] ex, ez;
   frac_type    f2x_ff, f2z_ff, fx1_ff, fz1_ff;
   weight_type  u_ff [2:6];
   weight_type  v_ff [2:8];

   always_comb begin
      sqx = fx_ff * fx_ff;
      sqz = fz_ff * fz_ff;
      kx  = EASE_THREE - {1'b0, fx1_ff, 1'b0};
      kz  = EASE_THREE - {1'b0, fz1_ff, 1'b0};
      ex  = f2x_ff * kx;
      ez  = f2z_ff * kz;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         f2x_ff <= sqx[31:16];
         f2z_ff <= sqz[31:16];
         fx1_ff <= fx_ff;
         fz1_ff <= fz_ff;
      end
      if (stage_en[2]) begin
         u_ff[2] <= ex[32:16];
         v_ff[2] <= ez[32:16];
      end
      for (int k = 3; k <= 6; k++) begin
         if (stage_en[k]) u_ff[k] <= u_ff[k-1];
      end
      for (int k = 3; k <= 8; k++) begin
         if (stage_en[k]) v_ff[k] <= v_ff[k-1];
      end
   end

   // stages 6..9: blend as c0 + (c1 - c0) * w, exact
   diff_type   d0_in, d1_in, d0_ff, d1_ff;
   corner_type c00_ff, c01_ff;
   logic signed [17:0] uw, vw;
   logic signed [36:0] p0, p1;
   row_type    row0_in, row1_in, row0_ff, row1_ff, row0d_ff;
   rdiff_type  dr_in, dr_ff;
   logic signed [52:0] pr;
   oct_type    oct_in, oct_ff;

   always_comb begin
      d0_in   = {c10[17], c10} - {c00[17], c00};
      d1_in   = {c11[17], c11} - {c01[17], c01};
      uw      = $signed({1'b0, u_ff[6]});
      p0      = d0_ff * uw;
      p1      = d1_ff * uw;
      row0_in = {c00_ff, 16'b0} + p0[33:0];
      row1_in = {c01_ff, 16'b0} + p1[33:0];
      dr_in   = {row1_ff[33], row1_ff} - {row0_ff[33], row0_ff};
      vw      = $signed({1'b0, v_ff[8]});
      pr      = dr_ff * vw;
      oct_in  = {row0d_ff, 16'b0} + pr[49:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         d0_ff  <= d0_in;
         d1_ff  <= d1_in;
         c00_ff <= c00;
         c01_ff <= c01;
      end
      if (stage_en[7]) begin
         row0_ff <= row0_in;
         row1_ff <= row1_in;
      end
      if (stage_en[8]) begin
         dr_ff    <= dr_in;
         row0d_ff <= row0_ff;
      end
      if (stage_en[9]) begin
         oct_ff <= oct_in;
      end
   end

   assign oct = oct_ff;

endmodule
`default_nettype wire

@@ rtl/value_noise_fbm.sv @@
// Top level: fractal value noise, octave lanes, weighted sum and normalization.
//
//  channel | dir | payload                            | transfer
//  --------+-----+------------------------------------+-------------------------
//  req_ch  | in  | coord_x, coord_z (s32, Q16.16)      | valid && ready
//  rsp_ch  | out | noise_value (s18, Q1.16)            | valid && ready
//
// Throughput is one transfer per cycle while the response side keeps ready high;
// a request passes through 15 register stages before response valid: 10 octave
// stages, pair sum, total, reciprocal multiply, remainder, correct/saturate.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor loads, so bubbles close up and a stalled response holds while
// requests keep entering until every stage is full.
// Reset clears only the valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module value_noise_fbm import vnf_pkg::*; #(
   parameter int OCTAVE_COUNT  = 4,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   vnf_req_if.sink    req_ch,
   vnf_rsp_if.source  rsp_ch
);

   localparam int SUM_W      = OCT_W + OCTAVE_COUNT;
   localparam int T_W        = SUM_W - 32;
   localparam int MP_W       = T_W + 34;
   localparam int Q_W        = T_W + 2;
   localparam int R_W        = T_W + OCTAVE_COUNT + 3;
   localparam int PAIRS      = (OCTAVE_COUNT + 1) / 2;
   localparam int ST_PAIR    = OCT_STAGES;
   localparam int ST_SUM     = OCT_STAGES + 1;
   localparam int ST_MUL     = OCT_STAGES + 2;
   localparam int ST_FIX     = OCT_STAGES + 3;
   localparam int ST_OUT     = OCT_STAGES + 4;
   localparam int PIPE_DEPTH = OCT_STAGES + 5;

   // sum of weights is (2^N - 1) / 2^(N-1); with the Q48 octave scale this
   // leaves floor((S >> 32) / (2^N - 1))
   localparam logic [33:0] DIVISOR = 34'((64'd1 << OCTAVE_COUNT) - 64'd1);
   localparam logic [33:0] RECIP   =
      34'(((64'd1 << 32) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
   localparam logic signed [R_W-1:0] DIV_R  = R_W'(DIVISOR);
   localparam logic signed [Q_W:0]   SAT_HI = (Q_W+1)'(65536);
   localparam logic signed [Q_W:0]   SAT_LO = -SAT_HI;

   // handshake: a stage loads when empty or when the next stage loads
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in, stage_en;

   always_comb begin
      stage_en[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp_ch.ready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_ch.valid : valid_ff[0];
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ch.ready = stage_en[0];

   // octave lanes
   oct_type oct_w [OCTAVE_COUNT];

   for (genvar i = 0; i < OCTAVE_COUNT; i++) begin : g_oct
      vnf_octave #(.OCTAVE(i), .FRACTION_BITS(FRACTION_BITS)) u_oct (
         .clock,
         .stage_en (stage_en[OCT_STAGES-1:0]),
         .coord_x  (req_ch.coord_x),
         .coord_z  (req_ch.coord_z),
         .oct      (oct_w[i])
      );
   end

   // weighted sum, octave i scaled by 2^(N-1-i); first level pairs lanes
   logic signed [SUM_W-1:0] pair_in [PAIRS];
   logic signed [SUM_W-1:0] pair_ff [PAIRS];

   for (genvar j = 0; j < PAIRS; j++) begin : g_pair
      if (2*j + 1 < OCTAVE_COUNT) begin : g_two
         assign pair_in[j] = (SUM_W'(oct_w[2*j]) <<< (OCTAVE_COUNT - 1 - 2*j))
                           + (SUM_W'(oct_w[2*j+1]) <<< (OCTAVE_COUNT - 2 - 2*j));
      end else begin : g_one
         assign pair_in[j] = SUM_W'(oct_w[2*j]) <<< (OCTAVE_COUNT - 1 - 2*j);
      end
   end

   logic signed [SUM_W-1:0] total;
   logic signed [T_W-1:0]   t_ff, t_d_ff;
   logic signed [MP_W-1:0]  prod_in, prod_ff;
   logic signed [Q_W-1:0]   q0, q0_ff;
   logic signed [R_W-1:0]   r_in, r_ff;
   logic signed [Q_W:0]     qc;
   noise_type               noise_in, noise_ff;

   always_comb begin
      total = '0;
      for (int j = 0; j < PAIRS; j++) begin
         total = total + pair_ff[j];
      end
      // floor(T / D) estimate, then one step of remainder correction
      prod_in = t_ff * $signed(RECIP);
      q0      = prod_ff[MP_W-1:32];
      r_in    = R_W'(t_d_ff) - (R_W'(q0) <<< OCTAVE_COUNT) + R_W'(q0);
      if (r_ff < 0) begin
         qc = (Q_W+1)'(q0_ff) - 2'sd1;
      end else if (r_ff >= DIV_R) begin
         qc = (Q_W+1)'(q0_ff) + 2'sd1;
      end else begin
         qc = (Q_W+1)'(q0_ff);
      end
      // guard only; a convex blend stays in range
      if (qc > SAT_HI) begin
         noise_in = ONE_Q16;
      end else if (qc < SAT_LO) begin
         noise_in = -ONE_Q16;
      end else begin
         noise_in = qc[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_PAIR]) begin
         pair_ff <= pair_in;
      end
      if (stage_en[ST_SUM]) begin
         t_ff <= total[SUM_W-1:32];
      end
      if (stage_en[ST_MUL]) begin
         prod_ff <= prod_in;
         t_d_ff  <= t_ff;
      end
      if (stage_en[ST_FIX]) begin
         q0_ff <= q0;
         r_ff  <= r_in;
      end
      if (stage_en[ST_OUT]) begin
         noise_ff <= noise_in;
      end
   end

   assign rsp_ch.valid       = valid_ff[ST_OUT];
   assign rsp_ch.noise_value = noise_ff;

endmodule
`default_nettype wire

@@ verif/vnf_noise_checker.sv @@
// Transfer monitor and scoreboard for the fractal value noise pipeline.
`timescale 1ns / 1ps
module vnf_noise_checker import vnf_pkg::*; #(
   parameter int OCTAVES   = 4,
   parameter int FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   vnf_req_if        req_ch,
   vnf_rsp_if        rsp_ch,
   output int        pending,
   output int        fail_count
);

   localparam logic [31:0] MIX_X     = 32'd73856093;
   localparam logic [31:0] MIX_Z     = 32'd19349663;
   localparam logic [31:0] MIX_SQ    = 32'd15731;
   localparam logic [31:0] MIX_LIN   = 32'd789221;
   localparam logic [31:0] MIX_OFS   = 32'd1376312589;
   localparam logic [31:0] LOW31     = 32'h7fff_ffff;
   localparam int          MIX_SHIFT = 13;
   localparam longint      UNIT      = 64'sd65536;
   localparam longint      FRAC_MASK = (64'sd1 <<< FRAC_BITS) - 64'sd1;

   noise_type noise_due[$];

   // corner value in Q.16, -65535 .. 65536
   function automatic longint lattice_value(input logic [31:0] cx, input logic [31:0] cz);
      logic [31:0] h;
      logic [31:0] m;
      longint      top_bits;
      h = (cx * MIX_X) ^ (cz * MIX_Z);
      h = (h << MIX_SHIFT) ^ h;
      m = (h * (h * h * MIX_SQ + MIX_LIN) + MIX_OFS) & LOW31;
      top_bits = 64'(m >> 14);
      return UNIT - top_bits;
   endfunction

   function automatic longint smooth(input longint f);
      longint f2;
      f2 = (f * f) >>> 16;
      return (f2 * (3 * UNIT - 2 * f)) >>> 16;
   endfunction

   // one octave, Q48
   function automatic longint octave_blend(input longint x, input longint z, input int oct);
      longint      sx, sz, fx, fz, ix, iz, qx, qz, u, v;
      longint      c00, c10, c01, c11, row0, row1;
      logic [31:0] lx, lz;
      sx = x * (64'sd1 <<< oct);
      sz = z * (64'sd1 <<< oct);
      fx = sx & FRAC_MASK;
      fz = sz & FRAC_MASK;
      ix = (sx - fx) >>> FRAC_BITS;
      iz = (sz - fz) >>> FRAC_BITS;
      lx = ix[31:0];
      lz = iz[31:0];
      if (FRAC_BITS >= 16) begin
         qx = fx >>> (FRAC_BITS - 16);
         qz = fz >>> (FRAC_BITS - 16);
      end else begin
         qx = fx <<< (16 - FRAC_BITS);
         qz = fz <<< (16 - FRAC_BITS);
      end
      u = smooth(qx);
      v = smooth(qz);
      c00 = lattice_value(lx, lz);
      c10 = lattice_value(lx + 32'd1, lz);
      c01 = lattice_value(lx, lz + 32'd1);
      c11 = lattice_value(lx + 32'd1, lz + 32'd1);
      row0 = c00 * (UNIT - u) + c10 * u;
      row1 = c01 * (UNIT - u) + c11 * u;
      return row0 * (UNIT - v) + row1 * v;
   endfunction

   function automatic noise_type fbm_expected(input coord_type cx, input coord_type cz);
      longint x, z, total, den, q;
      x = cx;
      z = cz;
      total = 0;
      for (int i = 0; i < OCTAVES; i++)
         total += octave_blend(x, z, i) * (64'sd1 <<< (OCTAVES - 1 - i));
      den = ((64'sd1 <<< OCTAVES) - 64'sd1) * (64'sd1 <<< 32);
      q = total / den;
      if (total % den != 0 && total < 0)
         q -= 1;
      if (q > UNIT)
         q = UNIT;
      if (q < -UNIT)
         q = -UNIT;
      return q[17:0];
   endfunction

   initial begin
      pending    = 0;
      fail_count = 0;
   end

   always @(posedge clock) begin
      noise_type due;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            noise_due.insert(noise_due.size(),
                             fbm_expected(req_ch.coord_x, req_ch.coord_z));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (noise_due.size() == 0) begin
               $error("noise_value: nothing expected, actual %0d", rsp_ch.noise_value);
               fail_count++;
            end else begin
               due = noise_due.pop_front();
               if (rsp_ch.noise_value !== due) begin
                  $error("noise_value: expected %0d, actual %0d", due, rsp_ch.noise_value);
                  fail_count++;
               end
            end
         end
      end
      pending = noise_due.size();
   end

endmodule

@@ verif/value_noise_fbm_test.sv @@
// Stimulus and verdict for the fractal value noise pipeline.
`timescale 1ns / 1ps
module value_noise_fbm_test;
   import vnf_pkg::*;

   localparam int OCTAVES      = 4;
   localparam int FRAC_BITS    = 16;
   localparam int RANDOM_ITEMS = 1100;
   // long receiver hold-off; far longer than the pipeline is deep
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 400;
   // drain time after the last response
   localparam int DRAIN_CYCLES = 40;
   // slowest legal run (receiver at 1 in 5) stays well under the limit
   localparam int CYCLE_LIMIT  = 150000;

   logic clock = 1'b0;
   logic reset;
   int   accepted_count = 0;
   int   cycle_count;
   int   pending;
   int   fail_count;

   vnf_req_if req_ch ();
   vnf_rsp_if rsp_ch ();

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   value_noise_fbm #(
      .OCTAVE_COUNT  (OCTAVES),
      .FRACTION_BITS (FRAC_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   vnf_noise_checker #(
      .OCTAVES   (OCTAVES),
      .FRAC_BITS (FRAC_BITS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .pending    (pending),
      .fail_count (fail_count)
   );

   // One request transfer. Called at a falling edge, returns at the falling
   // edge after the transfer so the caller can keep valid high or drop it.
   task automatic send_coord(input coord_type x, input coord_type z);
      req_ch.valid   <= 1'b1;
      req_ch.coord_x <= x;
      req_ch.coord_z <= z;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      accepted_count++;
      @(negedge clock);
   endtask

   // Coordinate mix: full-range words hit every bit; the rest stay near the
   // origin, on lattice lines, near the wrap points, or on fraction corners.
   function automatic coord_type pick_coord(input int kind);
      coord_type   c;
      logic [15:0] frac_pick;
      case (kind)
         0, 1, 2, 3: c = coord_type'($urandom());
         4, 5, 6: c = coord_type'($urandom_range(0, 20 * 65536)) - 32'sd655360;
         7: c = coord_type'((($urandom_range(0, 2000) - 32'd1000) << 16)
                            + $urandom_range(0, 2) - 32'd1);
         8: c = {($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000, 16'($urandom())};
         default: begin
            case ($urandom_range(0, 4))
               0:       frac_pick = 16'h0000;
               1:       frac_pick = 16'h0001;
               2:       frac_pick = 16'h7fff;
               3:       frac_pick = 16'h8000;
               default: frac_pick = 16'hffff;
            endcase
            c = {16'($urandom()), frac_pick};
         end
      endcase
      return c;
   endfunction

   // Receiver: runs of always-ready, coin-flip, three-in-four and sparse patterns. Once,
   // after enough transfers, it holds ready low for a long stretch while the
   // sender keeps pushing, so the pipeline fills and back-pressures.
   initial begin
      int  mode;
      int  span;
      int  step;
      bit  held_off;
      held_off = 1'b0;
      step     = 0;
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (!held_off && accepted_count >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++)
               @(negedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
               case (mode)
                  0:       rsp_ch.ready <= 1'b1;
                  1:       rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                  2:       rsp_ch.ready <= (step % 4 != 0);
                  default: rsp_ch.ready <= (step % 5 == 0);
               endcase
               step++;
               @(negedge clock);
            end
         end
      end
   end

   // Sender and verdict.
   initial begin
      int burst;
      int gap;
      int kind;
      int random_sent;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.coord_x <= '0;
      req_ch.coord_z <= '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: origin, extremes, lattice wrap at -1, fraction corners
      send_coord(32'sh0000_0000, 32'sh0000_0000);
      send_coord(32'sh7fff_ffff, 32'sh7fff_ffff);
      send_coord(32'sh8000_0000, 32'sh8000_0000);
      send_coord(32'sh7fff_ffff, 32'sh8000_0000);
      send_coord(32'sh8000_0000, 32'sh7fff_ffff);
      send_coord(32'shffff_ffff, 32'shffff_ffff);  // index -1, +1 wraps to 0
      send_coord(32'shffff_0000, 32'sh0000_0000);
      send_coord(32'sh0000_ffff, 32'sh0000_ffff);
      send_coord(32'sh0000_8000, 32'sh0000_8000);
      send_coord(32'sh0000_0001, 32'shffff_ffff);
      req_ch.valid <= 1'b0;
      repeat (3) @(negedge clock);
      send_coord(32'sh0005_0000, -32'sh0003_0000);
      send_coord(32'sh7fff_0000, 32'sh8000_ffff);
      send_coord(32'sh8000_0001, 32'sh7fff_fffe);
      send_coord(32'sh1fff_ffff, 32'she000_0000);  // scaled octaves leave the signed 32-bit range
      send_coord(32'sh5555_5555, 32'shaaaa_aaaa);
      send_coord(32'shaaaa_aaaa, 32'sh5555_5555);
      send_coord(32'sh0001_0000, 32'sh0001_0000);
      send_coord(-32'sh0000_8000, 32'sh0000_4000);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 40);
         if ($urandom_range(0, 3) == 0)
            burst = $urandom_range(60, 150);
         if (burst > RANDOM_ITEMS - random_sent)
            burst = RANDOM_ITEMS - random_sent;
         repeat (burst) begin
            kind = $urandom_range(0, 9);
            send_coord(pick_coord(kind), pick_coord(($urandom_range(0, 3) == 0) ?
                                                    $urandom_range(0, 9) : kind));
            random_sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_ch.valid <= 1'b0;

      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule
